>>> rtl/i2p_pkg.sv
`default_nettype none
package i2p_pkg;

    localparam int STACK_DEPTH_DEFAULT = 32;
    localparam int SYM_W = 8;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_OPEN  = 3'd5,
        OP_CLOSE = 3'd6
    } op_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_expr;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             symbol_valid;
        logic             last;
        logic [1:0]       error_code;
    } out_item_t;

    // request from the sequencer to the output stage
    typedef struct packed {
        logic             push;
        logic             drain;
        logic             finish;
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic [1:0]       error_code;
    } ob_ctl_t;

    typedef struct packed {
        logic emit_ok;
        logic out_free;
    } ob_sts_t;

    function automatic op_t classify(input logic [SYM_W-1:0] ch);
        op_t op;
        unique case (ch)
            8'h2B:   op = OP_ADD;
            8'h2D:   op = OP_SUB;
            8'h2A:   op = OP_MUL;
            8'h2F:   op = OP_DIV;
            8'h28:   op = OP_OPEN;
            8'h29:   op = OP_CLOSE;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic op_prio(input op_t op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    function automatic logic [SYM_W-1:0] op_char(input op_t op);
        logic [SYM_W-1:0] ch;
        unique case (op)
            OP_ADD:   ch = 8'h2B;
            OP_SUB:   ch = 8'h2D;
            OP_MUL:   ch = 8'h2A;
            OP_DIV:   ch = 8'h2F;
            OP_OPEN:  ch = 8'h28;
            OP_CLOSE: ch = 8'h29;
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> rtl/i2p_out_stage.sv
`default_nettype none
module i2p_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire i2p_pkg::ob_ctl_t   ctl,
    output i2p_pkg::ob_sts_t        sts,
    output i2p_pkg::out_item_t      m_item,
    output logic                    m_valid,
    input  wire logic               m_ready
);

    logic [i2p_pkg::SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic                      pend_sv_reg, pend_sv_next;
    logic                      pend_valid_reg, pend_valid_next;
    i2p_pkg::out_item_t        out_item_reg, out_item_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      out_free;
    logic                      emit_ok;

    assign out_free = !m_valid_reg || m_ready;
    assign emit_ok  = !pend_valid_reg || out_free;

    always_comb begin
        pend_sym_next   = pend_sym_reg;
        pend_sv_next    = pend_sv_reg;
        pend_valid_next = pend_valid_reg;
        out_item_next   = out_item_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (ctl.push && emit_ok) begin
            if (pend_valid_reg) begin
                out_item_next = '{out_symbol: pend_sym_reg, symbol_valid: pend_sv_reg,
                                  last: 1'b0, error_code: i2p_pkg::ERR_NONE};
                m_valid_next  = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = ctl.symbol;
            pend_sv_next    = ctl.symbol_valid;
        end else if (ctl.drain && pend_valid_reg && out_free) begin
            out_item_next   = '{out_symbol: pend_sym_reg, symbol_valid: pend_sv_reg,
                                last: 1'b0, error_code: i2p_pkg::ERR_NONE};
            m_valid_next    = 1'b1;
            pend_valid_next = 1'b0;
        end else if (ctl.finish && out_free) begin
            // final result of an expression carries last and the error
            out_item_next   = '{out_symbol: pend_sym_reg, symbol_valid: pend_sv_reg,
                                last: 1'b1, error_code: ctl.error_code};
            m_valid_next    = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_sym_reg <= pend_sym_next;
        pend_sv_reg  <= pend_sv_next;
        out_item_reg <= out_item_next;
    end

    assign sts.emit_ok  = emit_ok;
    assign sts.out_free = out_free;
    assign m_item       = out_item_reg;
    assign m_valid      = m_valid_reg;

endmodule
`default_nettype wire

>>> rtl/infix_to_postfix_converter_unit.sv
`default_nettype none
// an operand is accepted in S_IDLE and emitted from S_EXEC; an operator stays in S_EXEC while it pops stacked operators
// an end item then passes through S_FLOAD, S_FLUSH (one stacked entry flushed per step) and S_LAST for the final result
// each pop is one read of the stack memory (registered synchronous read)
// a result reaches m_valid through a pending stage
// reset clears stack count, error state and handshake registers; the stack memory is not cleared
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire i2p_pkg::in_item_t   s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output i2p_pkg::out_item_t       m_item
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FLOAD,
        S_FLUSH,
        S_LAST
    } state_t;

    state_t                    state_reg, state_next;
    logic [i2p_pkg::SYM_W-1:0] sym_reg, sym_next;
    logic                      end_reg, end_next;
    i2p_pkg::op_t              op_reg, op_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [1:0]                err_reg, err_next;
    logic                      step_emit_reg, step_emit_next;

    logic [2:0]                stack_mem [STACK_DEPTH];
    logic [2:0]                rd_data_reg;
    logic [AW-1:0]             mem_raddr;
    logic [CW-1:0]             rd_idx;
    logic                      wr_en;
    logic                      pop;

    i2p_pkg::ob_ctl_t          ob_ctl;
    i2p_pkg::ob_sts_t          ob_sts;

    i2p_pkg::op_t              top_op;
    logic                      have;
    logic                      full;
    logic                      top_open;
    state_t                    after_step;

    assign top_op     = i2p_pkg::op_t'(rd_data_reg);
    assign have       = count_reg != '0;
    assign full       = count_reg == CW'(STACK_DEPTH);
    assign top_open   = top_op == i2p_pkg::OP_OPEN;
    assign after_step = end_reg ? S_FLOAD : S_IDLE;
    assign s_ready    = state_reg == S_IDLE;

    always_comb begin
        state_next     = state_reg;
        sym_next       = sym_reg;
        end_next       = end_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        step_emit_next = step_emit_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        ob_ctl         = '0;

        unique case (state_reg)
            S_IDLE: begin
                ob_ctl.drain = 1'b1;
                if (s_valid) begin
                    sym_next       = s_item.symbol;
                    end_next       = s_item.end_of_expr;
                    op_next        = i2p_pkg::classify(s_item.symbol);
                    step_emit_next = 1'b0;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (op_reg) inside
                    i2p_pkg::OP_NONE: begin
                        ob_ctl.push         = 1'b1;
                        ob_ctl.symbol       = sym_reg;
                        ob_ctl.symbol_valid = 1'b1;
                        if (ob_sts.emit_ok) begin
                            step_emit_next = 1'b1;
                            state_next     = after_step;
                        end
                    end
                    i2p_pkg::OP_OPEN: begin
                        if (full) begin
                            if (err_reg == i2p_pkg::ERR_NONE) err_next = i2p_pkg::ERR_OVERFLOW;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        state_next = after_step;
                    end
                    i2p_pkg::OP_CLOSE: begin
                        if (!have) begin
                            if (err_reg == i2p_pkg::ERR_NONE) err_next = i2p_pkg::ERR_UNMATCHED;
                            state_next = after_step;
                        end else if (top_open) begin
                            pop        = 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = after_step;
                        end else begin
                            ob_ctl.push         = 1'b1;
                            ob_ctl.symbol       = i2p_pkg::op_char(top_op);
                            ob_ctl.symbol_valid = 1'b1;
                            if (ob_sts.emit_ok) begin
                                pop            = 1'b1;
                                count_next     = count_reg - 1'b1;
                                step_emit_next = 1'b1;
                            end
                        end
                    end
                    i2p_pkg::OP_ADD, i2p_pkg::OP_SUB, i2p_pkg::OP_MUL, i2p_pkg::OP_DIV: begin
                        if (have && !top_open &&
                            (i2p_pkg::op_prio(top_op) >= i2p_pkg::op_prio(op_reg))) begin
                            ob_ctl.push         = 1'b1;
                            ob_ctl.symbol       = i2p_pkg::op_char(top_op);
                            ob_ctl.symbol_valid = 1'b1;
                            if (ob_sts.emit_ok) begin
                                pop            = 1'b1;
                                count_next     = count_reg - 1'b1;
                                step_emit_next = 1'b1;
                            end
                        end else begin
                            if (full) begin
                                if (err_reg == i2p_pkg::ERR_NONE) begin
                                    err_next = i2p_pkg::ERR_OVERFLOW;
                                end
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = after_step;
                        end
                    end
                    default: state_next = after_step;
                endcase
            end
            S_FLOAD: begin
                state_next = S_FLUSH;
            end
            S_FLUSH: begin
                if (!have) begin
                    state_next = S_LAST;
                end else if (top_open) begin
                    pop        = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (err_reg == i2p_pkg::ERR_NONE) err_next = i2p_pkg::ERR_UNCLOSED;
                end else begin
                    ob_ctl.push         = 1'b1;
                    ob_ctl.symbol       = i2p_pkg::op_char(top_op);
                    ob_ctl.symbol_valid = 1'b1;
                    if (ob_sts.emit_ok) begin
                        pop            = 1'b1;
                        count_next     = count_reg - 1'b1;
                        step_emit_next = 1'b1;
                    end
                end
            end
            S_LAST: begin
                if (!step_emit_reg) begin
                    // bare end marker
                    ob_ctl.push = 1'b1;
                    if (ob_sts.emit_ok) step_emit_next = 1'b1;
                end else begin
                    ob_ctl.finish     = 1'b1;
                    ob_ctl.error_code = err_reg;
                    if (ob_sts.out_free) begin
                        err_next   = i2p_pkg::ERR_NONE;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // read the entry below the top when popping, the top otherwise
    assign rd_idx    = count_reg - (pop ? CW'(2) : CW'(1));
    assign mem_raddr = rd_idx[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[count_reg[AW-1:0]] <= op_reg;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= i2p_pkg::ERR_NONE;
            step_emit_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            step_emit_reg <= step_emit_next;
            sym_reg       <= sym_next;
            end_reg       <= end_next;
            op_reg        <= op_next;
        end
    end

    i2p_out_stage u_out_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ob_ctl),
        .sts     (ob_sts),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule
`default_nettype wire

>>> rtl/i2p_checker.sv
`default_nettype none
module i2p_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire i2p_pkg::in_item_t   s_item,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire i2p_pkg::out_item_t  m_item
);

    // a waiting input transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input changed while waiting");

    // a stalled transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // a bare end marker closes an expression and carries no character
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.symbol_valid |-> m_item.last && (m_item.out_symbol == 8'h00))
        else $error("bad end marker");

    // only the final result of an expression reports an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last |-> m_item.error_code == i2p_pkg::ERR_NONE)
        else $error("error code on a non-final result");

    // parentheses never reach the postfix output
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.symbol_valid |->
            (m_item.out_symbol != 8'h28) && (m_item.out_symbol != 8'h29))
        else $error("parenthesis in output");

endmodule

bind infix_to_postfix_converter_unit i2p_checker u_i2p_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire

>>> test/tb_top.sv
module tb_top;
    import i2p_pkg::*;

    typedef enum int {
        EXPR_CLEAN,
        EXPR_BROKEN,
        EXPR_DEEP,
        EXPR_NOISE
    } expr_kind_t;

    localparam int RUN_ITEMS = 320;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    infix_to_postfix_converter_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    in_item_t   char_q[$];
    out_item_t  postfix_q[$];
    out_item_t  step_out[$];
    op_t        op_stack[STACK_DEPTH_DEFAULT];
    int         op_depth     = 0;
    logic [1:0] expr_err     = ERR_NONE;
    int         n_total      = 0;
    int         n_accepted   = 0;
    int         mismatch_cnt = 0;
    int         gap_cnt      = 0;
    int         stall_cnt    = 0;
    bit         drv_calm     = 1'b0;
    bit         mon_calm     = 1'b0;
    string      op_text      = "+-*/()";

    function automatic op_t sym_kind(input logic [7:0] ch);
        case (ch)
            "+":     return OP_ADD;
            "-":     return OP_SUB;
            "*":     return OP_MUL;
            "/":     return OP_DIV;
            "(":     return OP_OPEN;
            ")":     return OP_CLOSE;
            default: return OP_NONE;
        endcase
    endfunction

    function automatic logic [7:0] sym_for(input op_t op);
        case (op)
            OP_ADD:  return "+";
            OP_SUB:  return "-";
            OP_MUL:  return "*";
            OP_DIV:  return "/";
            default: return 8'h00;
        endcase
    endfunction

    function automatic bit binds_tight(input op_t op);
        return op == OP_MUL || op == OP_DIV;
    endfunction

    function void note_err(input logic [1:0] code);
        if (expr_err == ERR_NONE) expr_err = code;
    endfunction

    function void emit_sym(input logic [7:0] ch);
        out_item_t r;
        r = '0;
        r.out_symbol   = ch;
        r.symbol_valid = 1'b1;
        step_out.push_back(r);
    endfunction

    function void push_op(input op_t op);
        if (op_depth >= STACK_DEPTH_DEFAULT) begin
            note_err(ERR_OVERFLOW);
        end else begin
            op_stack[op_depth] = op;
            op_depth++;
        end
    endfunction

    // expected postfix output for one accepted character
    function void convert_symbol(input in_item_t it);
        op_t       kind;
        op_t       t;
        bit        matched;
        out_item_t r;
        step_out.delete();
        kind = sym_kind(it.symbol);
        if (kind == OP_NONE) begin
            emit_sym(it.symbol);
        end else if (kind == OP_OPEN) begin
            push_op(kind);
        end else if (kind == OP_CLOSE) begin
            matched = 1'b0;
            while (op_depth > 0 && !matched) begin
                op_depth--;
                t = op_stack[op_depth];
                if (t == OP_OPEN) matched = 1'b1;
                else emit_sym(sym_for(t));
            end
            if (!matched) note_err(ERR_UNMATCHED);
        end else begin
            while (op_depth > 0 && op_stack[op_depth-1] != OP_OPEN &&
                   binds_tight(op_stack[op_depth-1]) >= binds_tight(kind)) begin
                emit_sym(sym_for(op_stack[op_depth-1]));
                op_depth--;
            end
            push_op(kind);
        end
        if (it.end_of_expr) begin
            while (op_depth > 0) begin
                op_depth--;
                t = op_stack[op_depth];
                if (t == OP_OPEN) note_err(ERR_UNCLOSED);
                else emit_sym(sym_for(t));
            end
            if (step_out.size() == 0) r = '0;
            else r = step_out.pop_back();
            r.last       = 1'b1;
            r.error_code = expr_err;
            step_out.push_back(r);
            expr_err = ERR_NONE;
        end
        foreach (step_out[i]) postfix_q.push_back(step_out[i]);
    endfunction

    function void add_item(input logic [7:0] ch, input bit eoe);
        in_item_t it;
        it.symbol      = ch;
        it.end_of_expr = eoe;
        char_q.push_back(it);
    endfunction

    function automatic void add_expr(input byte unsigned e[$]);
        foreach (e[i]) add_item(e[i], i == e.size() - 1);
    endfunction

    function automatic void add_text(input string s);
        byte unsigned e[$];
        for (int i = 0; i < s.len(); i++) e.push_back(s[i]);
        add_expr(e);
    endfunction

    function automatic byte unsigned rand_operand();
        byte unsigned c;
        do c = 8'($urandom_range(0, 255)); while (sym_kind(c) != OP_NONE);
        return c;
    endfunction

    function automatic byte unsigned rand_operator();
        return op_text[$urandom_range(0, 3)];
    endfunction

    function automatic void gen_expr(input expr_kind_t kind);
        byte unsigned e[$];
        int           terms;
        int           depth;
        depth = 0;
        case (kind)
            EXPR_DEEP: begin
                // nesting that may go past the stack size
                terms = $urandom_range(20, 36);
                for (int i = 0; i < terms; i++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        e.push_back(rand_operand());
                        e.push_back(rand_operator());
                    end
                    e.push_back("(");
                end
                e.push_back(rand_operand());
                depth = $urandom_range(terms - 2, terms + 1);
                for (int i = 0; i < depth; i++) e.push_back(")");
                add_expr(e);
            end
            EXPR_NOISE: begin
                terms = $urandom_range(1, 6);
                for (int i = 0; i < terms; i++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        add_item(op_text[$urandom_range(0, 5)], $urandom_range(0, 4) == 0);
                    end else begin
                        add_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
                    end
                end
            end
            default: begin
                terms = $urandom_range(1, 8);
                for (int i = 0; i < terms; i++) begin
                    if (i > 0) e.push_back(rand_operator());
                    while (depth < 6 && $urandom_range(0, 3) == 0) begin
                        e.push_back("(");
                        depth++;
                    end
                    e.push_back(rand_operand());
                    while (depth > 0 && $urandom_range(0, 2) == 0) begin
                        e.push_back(")");
                        depth--;
                    end
                end
                for (int i = 0; i < depth; i++) e.push_back(")");
                if (kind == EXPR_BROKEN) begin
                    case ($urandom_range(0, 2))
                        0:       e.insert($urandom_range(0, e.size() - 1), "(");
                        1:       e.insert($urandom_range(0, e.size() - 1), ")");
                        default: e.insert($urandom_range(0, e.size() - 1), rand_operator());
                    endcase
                end
                add_expr(e);
            end
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int         base;
        int         pick;
        expr_kind_t kind;
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b1);
        add_text("a-b/c*d+e");
        add_text("(");
        add_text(")");
        add_text("(a+b))*c");
        add_text("(x");
        add_text("a*");
        base = char_q.size();
        while (char_q.size() < base + RUN_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) kind = EXPR_CLEAN;
            else if (pick < 82) kind = EXPR_BROKEN;
            else if (pick < 87) kind = EXPR_DEEP;
            else kind = EXPR_NOISE;
            gen_expr(kind);
        end
        n_total = char_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_total) @(posedge aclk);
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt = 0;
        end else begin
            if (s_valid && s_ready) begin
                convert_symbol(s_item);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_cnt > 0) begin
                    s_valid <= 1'b0;
                    gap_cnt--;
                end else if (char_q.size() > 0) begin
                    s_item  <= char_q.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 24) == 0) drv_calm = !drv_calm;
                    gap_cnt = drv_calm ? 0 : $urandom_range(0, 18);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (postfix_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected transfer sym=%h valid=%b last=%b err=%0d",
                             $time, m_item.out_symbol, m_item.symbol_valid,
                             m_item.last, m_item.error_code);
                end else begin
                    want = postfix_q.pop_front();
                    if (m_item.out_symbol !== want.out_symbol ||
                        m_item.symbol_valid !== want.symbol_valid ||
                        m_item.last !== want.last ||
                        m_item.error_code !== want.error_code) begin
                        mismatch_cnt++;
                        $display({"%0t: mismatch expected sym=%h valid=%b last=%b err=%0d",
                                  " actual sym=%h valid=%b last=%b err=%0d"},
                                 $time, want.out_symbol, want.symbol_valid, want.last,
                                 want.error_code, m_item.out_symbol,
                                 m_item.symbol_valid, m_item.last, m_item.error_code);
                    end
                end
                if ($urandom_range(0, 24) == 0) mon_calm = !mon_calm;
                stall_cnt = mon_calm ? 0 : $urandom_range(0, 18);
            end
            if (stall_cnt > 0) begin
                m_ready <= 1'b0;
                stall_cnt--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule

>>> sim.f
rtl/i2p_pkg.sv
rtl/i2p_out_stage.sv
rtl/infix_to_postfix_converter_unit.sv
rtl/i2p_checker.sv
test/tb_top.sv
